// File: hw/rtl/crc8_pcm_frame_deframer_macros.svh
// ---------------------------------------------------------------------------
// crc8_pcm_frame_deframer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CRC8_PCM_FRAME_DEFRAMER_MACROS_SVH
`define CRC8_PCM_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define CRC8PCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crc8pcm assertion failed");

// next-cycle implication
`define CRC8PCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crc8pcm assertion failed");

`endif

// File: hw/rtl/crc8pcm_pkg.sv
// ---------------------------------------------------------------------------
// crc8pcm_pkg
// Shared types, constants and the CRC-8 byte update for the deframer.
// ---------------------------------------------------------------------------
package crc8pcm_pkg;

  // header and crc constants
  localparam logic [7:0]  SyncFirst     = 8'hAA;
  localparam logic [7:0]  SyncSecond    = 8'h55;
  localparam logic [7:0]  CrcPoly       = 8'h07;
  localparam logic [7:0]  CrcInit       = 8'h00;
  localparam logic [15:0] MaxFrameReset = 16'd4096;

  // result kinds
  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindGood   = 2'd1;
  localparam logic [1:0] KindCrcErr = 2'd2;
  localparam logic [1:0] KindBadLen = 2'd3;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    OP_PAY_LO  = 2'd0,
    OP_PAY_HI  = 2'd1,
    OP_CRC     = 2'd2,
    OP_BAD_LEN = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        first;
    logic [7:0]  data;
    logic [15:0] len;
  } op_entry_t;

  // crc-8, poly 0x07, msb first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/crc8pcm_front.sv
// ---------------------------------------------------------------------------
// crc8pcm_front
// Header parser: sync hunt, length capture and check, payload counting.
// Emits one work op per byte that needs the back end.
// ---------------------------------------------------------------------------
module crc8pcm_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [15:0]            cfg_wdata_i,
  input  logic                   accept_i,
  input  logic [7:0]             rx_byte_i,
  output logic                   op_valid_o,
  output crc8pcm_pkg::op_entry_t op_o
);
  import crc8pcm_pkg::*;

  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhSync2   = 3'd1;
  localparam logic [2:0] PhLenHi   = 3'd2;
  localparam logic [2:0] PhLenLo   = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhCrc     = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] max_q;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;

  // max frame register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxFrameReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  assign len_full = {len_q[15:8], rx_byte_i};
  assign cnt_inc  = cnt_q + 16'd1;

  // phase decode per byte
  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    op_valid_o = 1'b0;
    op_o.op    = OP_PAY_LO;
    op_o.first = 1'b0;
    op_o.data  = rx_byte_i;
    op_o.len   = len_q;
    if (accept_i) begin
      unique case (phase_q)
        PhSync2: begin
          phase_d = (rx_byte_i == SyncSecond) ? PhLenHi : PhHunt;
        end
        PhLenHi: begin
          len_d   = {rx_byte_i, 8'h00};
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_d = len_full;
          cnt_d = '0;
          if (len_full == 16'd0 || len_full > max_q) begin
            op_valid_o = 1'b1;
            op_o.op    = OP_BAD_LEN;
            op_o.len   = len_full;
            phase_d    = PhHunt;
          end else begin
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          op_valid_o = 1'b1;
          op_o.op    = cnt_q[0] ? OP_PAY_HI : OP_PAY_LO;
          op_o.first = (cnt_q == 16'd0);
          cnt_d      = cnt_inc;
          if (cnt_inc == len_q) begin
            phase_d = PhCrc;
          end
        end
        PhCrc: begin
          op_valid_o = 1'b1;
          op_o.op    = OP_CRC;
          phase_d    = PhHunt;
        end
        default: begin
          phase_d = (rx_byte_i == SyncFirst) ? PhSync2 : PhHunt;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  `include "crc8_pcm_frame_deframer_macros.svh"

  `CRC8PCM_ASSERT_NOW(a_cnt_below_len, phase_q == PhPayload, cnt_q < len_q)
  `CRC8PCM_ASSERT_NEXT(a_crc_ends_frame, op_valid_o && op_o.op == OP_CRC, phase_q == PhHunt)

endmodule

// File: hw/rtl/crc8pcm_queue.sv
// ---------------------------------------------------------------------------
// crc8pcm_queue
// Small register queue of work ops between the front and the back.
// ---------------------------------------------------------------------------
module crc8pcm_queue #(
  parameter int Depth = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  crc8pcm_pkg::op_entry_t wr_entry_i,
  input  logic                   pop_i,
  output crc8pcm_pkg::op_entry_t rd_entry_o,
  output logic                   full_o,
  output logic                   empty_o
);
  import crc8pcm_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  op_entry_t       entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push_en, pop_en;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign push_en    = push_i && !full_o;
  assign pop_en     = pop_i && !empty_o;
  assign rd_entry_o = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      entry_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_en && !pop_en) begin
        count_q <= count_q + 1'b1;
      end else if (pop_en && !push_en) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `include "crc8_pcm_frame_deframer_macros.svh"

  `CRC8PCM_ASSERT_NOW(a_full_not_empty, full_o, !empty_o)
  `CRC8PCM_ASSERT_NEXT(a_push_grows, push_en && !pop_en, count_q == $past(count_q) + 1'b1)

endmodule

// File: hw/rtl/crc8pcm_back.sv
// ---------------------------------------------------------------------------
// crc8pcm_back
// Runs the payload crc, pairs bytes into samples and builds result beats
// in an output register.
// ---------------------------------------------------------------------------
module crc8pcm_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  crc8pcm_pkg::op_entry_t entry_i,
  output logic                   q_pop_o,
  input  logic                   pop,
  output logic                   empty,
  output logic [1:0]             kind_o,
  output logic signed [15:0]     sample_o,
  output logic [15:0]            frame_bytes_o,
  output logic [7:0]             crc_value_o
);
  import crc8pcm_pkg::*;

  logic        res_valid_q;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] sample_q, sample_d;
  logic [15:0] fbytes_q, fbytes_d;
  logic [7:0]  crcv_q, crcv_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  hold_q, hold_d;
  logic [7:0]  crc_base;
  logic        out_free;
  logic        gives_result;

  assign out_free     = !res_valid_q || pop;
  assign gives_result = (entry_i.op != OP_PAY_LO);
  assign q_pop_o      = !q_empty_i && (!gives_result || out_free);
  assign crc_base     = entry_i.first ? CrcInit : crc_q;

  // op execution
  always_comb begin
    crc_d    = crc_q;
    hold_d   = hold_q;
    kind_d   = KindSample;
    sample_d = '0;
    fbytes_d = '0;
    crcv_d   = '0;
    unique case (entry_i.op)
      OP_PAY_LO: begin
        crc_d  = crc8_update(crc_base, entry_i.data);
        hold_d = entry_i.data;
      end
      OP_PAY_HI: begin
        crc_d    = crc8_update(crc_base, entry_i.data);
        sample_d = {entry_i.data, hold_q};
      end
      OP_CRC: begin
        kind_d   = (entry_i.data == crc_q) ? KindGood : KindCrcErr;
        fbytes_d = entry_i.len;
        crcv_d   = crc_q;
      end
      default: begin
        kind_d   = KindBadLen;
        fbytes_d = entry_i.len;
      end
    endcase
  end

  // crc and low byte state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      hold_q <= '0;
    end else if (q_pop_o) begin
      crc_q  <= crc_d;
      hold_q <= hold_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (q_pop_o && gives_result) begin
      res_valid_q <= 1'b1;
    end else if (pop) begin
      res_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o && gives_result) begin
      kind_q   <= kind_d;
      sample_q <= sample_d;
      fbytes_q <= fbytes_d;
      crcv_q   <= crcv_d;
    end
  end

  assign empty         = !res_valid_q;
  assign kind_o        = kind_q;
  assign sample_o      = $signed(sample_q);
  assign frame_bytes_o = fbytes_q;
  assign crc_value_o   = crcv_q;

  `include "crc8_pcm_frame_deframer_macros.svh"

  `CRC8PCM_ASSERT_NEXT(a_hi_gives_sample, q_pop_o && entry_i.op == OP_PAY_HI, res_valid_q && kind_q == KindSample)
  `CRC8PCM_ASSERT_NOW(a_no_load_over_result, q_pop_o && gives_result, !res_valid_q || pop)

endmodule

// File: hw/rtl/crc8_pcm_frame_deframer.sv
// ---------------------------------------------------------------------------
// crc8_pcm_frame_deframer
// Length-prefixed PCM frame deframer with CRC-8 payload check.
// ---------------------------------------------------------------------------
// Takes one received byte per clock while full is low and gives sample,
// frame-good, crc-mismatch and bad-length result beats in arrival order. A
// result is registered in the op queue and then in the output register, with
// no extra wait when the op queue is empty and no earlier result is waiting.
// The header parser takes a byte every cycle as long as the op queue
// (QueueDepth entries) has room; the back end retires one op a cycle unless
// stalled, so the queue only fills while the consumer holds pop low with a
// result waiting. max_frame_bytes resets to 4096; the user must write it
// through cfg_we_i / cfg_wdata_i while the block is idle (not enforced).
module crc8_pcm_frame_deframer #(
  parameter int QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic signed [15:0] sample_o,
  output logic [15:0]        frame_bytes_o,
  output logic [7:0]         crc_value_o
);
  import crc8pcm_pkg::*;

  logic      accept;
  logic      op_valid;
  op_entry_t op_wr;
  op_entry_t op_rd;
  logic      q_full, q_empty, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  // header parser and classifier
  crc8pcm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .op_valid_o (op_valid),
    .op_o       (op_wr)
  );

  // op queue
  crc8pcm_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (op_valid),
    .wr_entry_i(op_wr),
    .pop_i     (q_pop),
    .rd_entry_o(op_rd),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // crc, sample packing and result register
  crc8pcm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .entry_i      (op_rd),
    .q_pop_o      (q_pop),
    .pop          (pop),
    .empty        (empty),
    .kind_o       (kind_o),
    .sample_o     (sample_o),
    .frame_bytes_o(frame_bytes_o),
    .crc_value_o  (crc_value_o)
  );

endmodule

// File: sim/tb_crc8_pcm_frame_deframer.sv
// ---------------------------------------------------------------------------
// tb_crc8_pcm_frame_deframer
// Drives received bytes into the deframer with random gaps and pops results
// with random stalls. A scoreboard tracks sync, length, payload and crc
// phases and predicts each sample and status beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_crc8_pcm_frame_deframer;
  import crc8pcm_pkg::*;

  localparam int IdleLimit    = 2000;
  localparam int SettleCycles = 12;

  typedef logic [7:0] byte_q_t[$];

  // receive phases of the frame parser
  typedef enum logic [2:0] {
    WAIT_SYNC1,
    WAIT_SYNC2,
    LEN_HI,
    LEN_LO,
    PAYLOAD,
    CRC_BYTE
  } rx_phase_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [15:0]        frame_bytes;
    logic [7:0]         crc;
  } beat_t;

  // frame parser copy and queue of expected beats
  class frame_scoreboard;
    rx_phase_e   phase;
    logic [15:0] max_bytes;
    logic [15:0] hdr_len;
    logic [15:0] body_cnt;
    logic [7:0]  crc_acc;
    logic [7:0]  lo_hold;
    beat_t       expected_beats[$];
    int          errors;

    function new();
      phase     = WAIT_SYNC1;
      max_bytes = MaxFrameReset;
      hdr_len   = '0;
      body_cnt  = '0;
      crc_acc   = '0;
      lo_hold   = '0;
      errors    = 0;
    endfunction

    // bit-serial crc-8, msb first
    static function logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb  = crc[7] ^ d[i];
        crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
      end
      return crc;
    endfunction

    // advance the parser by one accepted byte
    function void take_byte(input logic [7:0] b);
      beat_t r;
      r = '0;
      case (phase)
        WAIT_SYNC2: begin
          if (b == SyncSecond) phase = LEN_HI;
          else phase = WAIT_SYNC1;
        end
        LEN_HI: begin
          hdr_len = {b, 8'h00};
          phase   = LEN_LO;
        end
        LEN_LO: begin
          hdr_len[7:0] = b;
          if (hdr_len == 16'd0 || hdr_len > max_bytes) begin
            r.kind        = KindBadLen;
            r.frame_bytes = hdr_len;
            expected_beats = {expected_beats, r};
            phase = WAIT_SYNC1;
          end else begin
            body_cnt = '0;
            crc_acc  = CrcInit;
            phase    = PAYLOAD;
          end
        end
        PAYLOAD: begin
          crc_acc = crc_next(crc_acc, b);
          if (!body_cnt[0]) begin
            lo_hold = b;
          end else begin
            r.kind   = KindSample;
            r.sample = {b, lo_hold};
            expected_beats = {expected_beats, r};
          end
          body_cnt = body_cnt + 16'd1;
          if (body_cnt == hdr_len) phase = CRC_BYTE;
        end
        CRC_BYTE: begin
          r.kind        = (b == crc_acc) ? KindGood : KindCrcErr;
          r.frame_bytes = hdr_len;
          r.crc         = crc_acc;
          expected_beats = {expected_beats, r};
          phase = WAIT_SYNC1;
        end
        default: begin
          if (b == SyncFirst) phase = WAIT_SYNC2;
          else phase = WAIT_SYNC1;
        end
      endcase
    endfunction

    function void report(input string field, input int want, input int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    // compare one popped beat with the oldest expectation
    function void check_beat(input beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none actual kind %0d sample %0d len %0d crc %0d",
                 $time, got.kind, got.sample, got.frame_bytes, got.crc);
        return;
      end
      want = expected_beats[0];
      expected_beats.delete(0);
      if (got.kind !== want.kind) report("kind", want.kind, got.kind);
      if (got.sample !== want.sample) report("sample", want.sample, got.sample);
      if (got.frame_bytes !== want.frame_bytes)
        report("frame_bytes", want.frame_bytes, got.frame_bytes);
      if (got.crc !== want.crc) report("crc_value", want.crc, got.crc);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         rx_byte = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         kind;
  logic signed [15:0] sample;
  logic [15:0]        frame_bytes;
  logic [7:0]         crc_value;

  frame_scoreboard frames;
  bit              byte_fire;
  bit              beat_fire;
  logic [7:0]      rx_seen;
  beat_t           beat_seen;
  int              bytes_sent;
  int              stall_cycles;
  int              tx_left;
  bit              tx_calm;

  always #5 clk = ~clk;

  crc8_pcm_frame_deframer i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .push         (push),
    .full         (full),
    .rx_byte_i    (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind),
    .sample_o     (sample),
    .frame_bytes_o(frame_bytes),
    .crc_value_o  (crc_value)
  );

  // settle handshakes mid-cycle, act on them at the next rising edge
  always @(negedge clk) begin
    byte_fire             = rst_n && push && (full === 1'b0);
    beat_fire             = rst_n && pop && (empty === 1'b0);
    rx_seen               = rx_byte;
    beat_seen.kind        = kind;
    beat_seen.sample      = sample;
    beat_seen.frame_bytes = frame_bytes;
    beat_seen.crc         = crc_value;
  end

  always @(posedge clk) begin
    if (byte_fire) frames.take_byte(rx_seen);
    if (beat_fire) frames.check_beat(beat_seen);
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (byte_fire || beat_fire) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= IdleLimit) begin
        $display("tb_crc8_pcm_frame_deframer NOT OK");
        $finish;
      end
    end
  end

  // result side: random stalls with calm stretches
  initial begin
    int rx_gap;
    int rx_left;
    bit rx_calm;
    rx_left = 0;
    rx_calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_left == 0) begin
        rx_left = $urandom_range(20, 80);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      rx_left--;
      rx_gap = rx_calm ? 0 : $urandom_range(0, 13);
      if (rx_gap > 0) begin
        pop <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (!beat_fire);
    end
  end

  // push one byte after a random gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_left == 0) begin
      tx_left = $urandom_range(20, 80);
      tx_calm = ($urandom_range(0, 3) == 0);
    end
    tx_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!byte_fire);
    bytes_sent++;
  endtask

  // header, payload and optionally a good or corrupted crc byte
  task automatic send_frame(input logic [15:0] hdr_len, input byte_q_t body,
                            input bit with_crc, input bit crc_ok);
    logic [7:0] crc;
    crc = CrcInit;
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(hdr_len[15:8]);
    send_byte(hdr_len[7:0]);
    foreach (body[i]) begin
      crc = frame_scoreboard::crc_next(crc, body[i]);
      send_byte(body[i]);
    end
    if (with_crc) send_byte(crc_ok ? crc : crc ^ 8'($urandom_range(1, 255)));
  endtask

  // drain the block, then load a new maximum length
  task automatic write_max_bytes(input logic [15:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (frames.expected_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    frames.max_bytes = v;
  endtask

  // mostly well-formed frames, some bad lengths, broken syncs and noise
  task automatic run_random(input int count);
    int          stop;
    int          pick;
    int          lim;
    int          n;
    logic [15:0] m;
    logic [15:0] len;
    logic [7:0]  b;
    byte_q_t     body;
    m    = frames.max_bytes;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 99);
      body = {};
      if (pick < 72 && m != 16'd0) begin
        lim = (m < 16'd24) ? int'(m) : 24;
        n   = ($urandom_range(0, 9) == 0) ? lim : $urandom_range(1, lim);
        repeat (n) body = {body, 8'($urandom)};
        if (pick < 3) begin
          // truncated frame, the following bytes get eaten as payload
          void'(body.pop_back());
          send_frame(16'(n), body, 1'b0, 1'b0);
        end else begin
          send_frame(16'(n), body, 1'b1, $urandom_range(0, 3) != 0);
        end
      end else if (pick < 82) begin
        if (m == 16'hFFFF || $urandom_range(0, 2) == 0) len = 16'd0;
        else len = 16'($urandom_range(int'(m) + 1, 65535));
        send_frame(len, body, 1'b0, 1'b0);
      end else if (pick < 90) begin
        b = 8'($urandom);
        if (b == SyncSecond) b = SyncFirst;
        send_byte(SyncFirst);
        send_byte(b);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    byte_q_t none;
    none         = {};
    frames       = new();
    bytes_sent   = 0;
    stall_cycles = 0;
    tx_left      = 0;
    tx_calm      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // noise, broken sync where the second 0xAA is dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SyncFirst);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    // zero length and one past the reset maximum
    send_frame(16'd0, none, 1'b0, 1'b0);
    send_frame(16'd4097, none, 1'b0, 1'b0);
    // extreme samples, good crc
    send_frame(16'd4, {8'h00, 8'h80, 8'hFF, 8'h7F}, 1'b1, 1'b1);
    // odd length with crc mismatch, last byte gives no sample
    send_frame(16'd1, {8'hFF}, 1'b1, 1'b0);

    // zero maximum rejects every length
    write_max_bytes(16'd0);
    send_frame(16'hFFFF, none, 1'b0, 1'b0);
    send_frame(16'd1, none, 1'b0, 1'b0);

    write_max_bytes(16'd1);
    send_frame(16'd1, {8'h55}, 1'b1, 1'b1);
    send_frame(16'd2, none, 1'b0, 1'b0);
    run_random(200);

    write_max_bytes(16'hFFFF);
    run_random(300);

    write_max_bytes(16'($urandom_range(2, 60)));
    run_random(300);

    write_max_bytes(MaxFrameReset);
    run_random(300);

    write_max_bytes(16'd5);
    run_random(300);

    // let every expected beat arrive, then watch for strays
    push <= 1'b0;
    @(posedge clk);
    while (frames.expected_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (frames.errors == 0) begin
      $display("tb_crc8_pcm_frame_deframer OK");
    end else begin
      $display("tb_crc8_pcm_frame_deframer NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/crc8pcm_pkg.sv
hw/rtl/crc8pcm_front.sv
hw/rtl/crc8pcm_queue.sv
hw/rtl/crc8pcm_back.sv
hw/rtl/crc8_pcm_frame_deframer.sv
sim/tb_crc8_pcm_frame_deframer.sv
